// ===== rtl/spi_pkg.sv =====
// Shared constants, command codes and the queue entry type for the sampler voice.
// Used by every module of the block except spi_ram; depends on nothing.
`default_nettype none

package spi_pkg;

    // sizing
    localparam int MAX_SAMPLES = 65536;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int LEN_W       = 17;
    localparam int LEN_CAP     = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;
    localparam int POS_W       = LEN_W + FRAC_BITS;
    localparam int SAMPLE_W    = 16;
    localparam int SPEED_W     = 24;
    localparam int CFG_W       = 24;
    localparam int CFG_IDX_W   = 2;

    // input commands
    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_PLAY   = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_PAUSE  = 3'd3;
    localparam logic [2:0] CMD_RESUME = 3'd4;
    localparam logic [2:0] CMD_TICK   = 3'd5;
    localparam logic [2:0] CMD_SEEK   = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP  = 2'd2;

    // what the back end has to do for one request
    typedef enum logic [1:0] {
        OP_PLAIN,
        OP_WRITE,
        OP_INTERP
    } op_kind_t;

    typedef struct packed {
        op_kind_t                    kind;
        logic [ADDR_W-1:0]           addr;
        logic signed [SAMPLE_W-1:0]  wdata;
        logic [LEN_W-1:0]            pos_idx;
        logic [FRAC_BITS-1:0]        frac;
        logic                        playing;
        logic                        paused;
    } op_t;

endpackage

`default_nettype wire

// ===== rtl/spi_ram.sv =====
// Generic single-port RAM with registered read data (read-first on write).
// No dependencies.
`default_nettype none

module spi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // one access per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/spi_front.sv =====
// Front end: holds play position and flags, applies each command at once and
// builds the queue entry for the back end. Depends on spi_pkg.
`default_nettype none

module spi_front
    import spi_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       accept,
    input  wire logic [2:0]                 cmd,
    input  wire logic [15:0]                sample_index,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    input  wire logic [16:0]                seek_fraction,
    input  wire logic signed [SPEED_W-1:0]  speed,
    input  wire logic                       loop_enable,
    input  wire logic [LEN_W-1:0]           len,
    output op_t                             op
);

    localparam int SPD_SHL = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SPD_SHR = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int SPD_W   = SPEED_W + SPD_SHL;
    localparam int SUM_W   = POS_W + 2;
    localparam int IP_W    = SUM_W - FRAC_BITS;
    localparam int SEEK_W  = 2 * LEN_W + SPD_SHL;

    // Q8.16 speed to the position format, floor when fraction bits drop
    function automatic logic signed [SPD_W-1:0] speed_to_pos(
        input logic signed [SPEED_W-1:0] v
    );
        logic signed [SPD_W-1:0] w;
        w = SPD_W'(v);
        w = (w <<< SPD_SHL) >>> SPD_SHR;
        return w;
    endfunction

    logic [POS_W-1:0]        pos_reg, pos_next;
    logic                    playing_reg, playing_next;
    logic                    paused_reg, paused_next;
    logic [POS_W-1:0]        len_pos;
    logic signed [SUM_W-1:0] tick_sum;
    logic signed [IP_W-1:0]  tick_ip;
    logic                    past_end, below_zero, active;
    logic [LEN_W-1:0]        seek_clamp;
    logic [2*LEN_W-1:0]      seek_prod;
    logic [SEEK_W-1:0]       seek_wide;
    logic [POS_W-1:0]        seek_pos;
    logic                    in_range;
    op_kind_t                kind;

    // tick arithmetic
    assign len_pos    = {len, {FRAC_BITS{1'b0}}};
    assign tick_sum   = $signed({2'b00, pos_reg}) + SUM_W'(speed_to_pos(speed));
    assign tick_ip    = tick_sum[SUM_W-1:FRAC_BITS];
    assign past_end   = tick_ip > $signed(IP_W'(len));
    assign below_zero = tick_sum[SUM_W-1];
    assign active     = playing_reg && !paused_reg && (len != '0);

    // seek target, fraction of the length
    assign seek_clamp = (seek_fraction > 17'h10000) ? 17'h10000 : seek_fraction;
    assign seek_prod  = seek_clamp * len;
    assign seek_wide  = SEEK_W'(seek_prod) << SPD_SHL;
    assign seek_pos   = POS_W'(seek_wide >> SPD_SHR);

    assign in_range = 32'(sample_index) < 32'(MAX_SAMPLES);

    // command decode
    always_comb
    begin
        pos_next     = pos_reg;
        playing_next = playing_reg;
        paused_next  = paused_reg;
        kind         = OP_PLAIN;
        case (cmd)
            CMD_WRITE:
            begin
                kind = in_range ? OP_WRITE : OP_PLAIN;
            end
            CMD_PLAY:
            begin
                pos_next     = (speed > 24'sd0) ? '0 : len_pos;
                playing_next = 1'b1;
            end
            CMD_STOP:
            begin
                pos_next     = '0;
                playing_next = 1'b0;
                paused_next  = 1'b0;
            end
            CMD_PAUSE:
            begin
                paused_next = 1'b1;
            end
            CMD_RESUME:
            begin
                paused_next = 1'b0;
            end
            CMD_TICK:
            begin
                if (active)
                begin
                    if (past_end)
                    begin
                        if (loop_enable)
                        begin
                            pos_next = '0;
                            kind     = OP_INTERP;
                        end
                        else
                        begin
                            pos_next     = len_pos;
                            playing_next = 1'b0;
                        end
                    end
                    else if (below_zero)
                    begin
                        if (loop_enable)
                        begin
                            pos_next = len_pos;
                            kind     = OP_INTERP;
                        end
                        else
                        begin
                            pos_next     = '0;
                            playing_next = 1'b0;
                        end
                    end
                    else
                    begin
                        pos_next = POS_W'(tick_sum);
                        kind     = OP_INTERP;
                    end
                end
            end
            CMD_SEEK:
            begin
                pos_next = seek_pos;
            end
            default:
            begin
                kind = OP_PLAIN;
            end
        endcase
    end

    // queue entry
    always_comb
    begin
        op.kind    = kind;
        op.addr    = ADDR_W'(sample_index);
        op.wdata   = sample_value;
        op.pos_idx = pos_next[POS_W-1:FRAC_BITS];
        op.frac    = pos_next[FRAC_BITS-1:0];
        op.playing = playing_next;
        op.paused  = paused_next;
    end

    // voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            playing_reg <= 1'b0;
            paused_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            playing_reg <= playing_next;
            paused_reg  <= paused_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spi_queue.sv =====
// Two-entry request queue between the front end and the back end.
// Depends on spi_pkg for the entry type.
`default_nettype none

module spi_queue
    import spi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  op_t       push_op,
    input  wire logic pop,
    output op_t       head_op,
    output logic      head_valid,
    output logic      full
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_t              entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign head_op    = entry_reg[rd_ptr_reg];
    assign head_valid = count_reg != '0;
    assign full       = count_reg == CNT_W'(DEPTH);

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/spi_back.sv =====
// Back end: sample memory accesses, interpolation pipeline and result register.
// Depends on spi_pkg and spi_ram.
`default_nettype none

module spi_back
    import spi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  op_t                       head_op,
    input  wire logic                 head_valid,
    output logic                      pop,
    input  wire logic [LEN_W-1:0]     len,
    input  wire logic                 out_stall,
    output logic                      out_valid,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                      is_playing,
    output logic                      is_paused,
    output logic [LEN_W-1:0]          position_index
);

    localparam int PROD_W = FRAC_BITS + SAMPLE_W + 2;
    localparam int PSUM_W = PROD_W + 1;

    logic                        en;
    logic                        phase_reg;
    logic                        ram_en, ram_we;
    logic [ADDR_W-1:0]           ram_addr;
    logic [SAMPLE_W-1:0]         ram_rdata;
    logic [LEN_W:0]              idx_a, idx_b;
    logic                        ok_a, ok_b;
    logic                        is_interp;

    logic                        d_valid_reg;
    op_t                         d_op_reg;
    logic                        d_ok_a_reg, d_ok_b_reg;
    logic signed [SAMPLE_W-1:0]  a_data_reg;
    logic signed [SAMPLE_W-1:0]  a_val, b_val;
    logic [FRAC_BITS:0]          w_a;
    logic signed [PROD_W-1:0]    prod_a, prod_b;

    logic                        m_valid_reg;
    op_t                         m_op_reg;
    logic signed [PROD_W-1:0]    m_prod_a_reg, m_prod_b_reg;
    logic signed [PSUM_W-1:0]    m_sum;

    logic                        out_valid_reg;
    logic signed [SAMPLE_W-1:0]  sample_out_reg;
    logic                        is_playing_reg;
    logic                        is_paused_reg;
    logic [LEN_W-1:0]            position_index_reg;

    // whole pipeline moves unless a finished result is held
    assign en = !out_valid_reg || !out_stall;

    // issue stage: one memory access per cycle while the pipeline moves, two accesses for an interpolation
    assign is_interp = head_valid && (head_op.kind == OP_INTERP);
    assign idx_a     = {1'b0, head_op.pos_idx} + 1'b1;
    assign idx_b     = {1'b0, head_op.pos_idx} + 2'd2;
    assign ok_a      = idx_a < {1'b0, len};
    assign ok_b      = idx_b < {1'b0, len};
    assign pop       = en && head_valid && (!is_interp || phase_reg);

    assign ram_en   = en;
    assign ram_we   = en && head_valid && (head_op.kind == OP_WRITE);
    assign ram_addr = (head_op.kind == OP_WRITE) ? head_op.addr :
                      (phase_reg ? ADDR_W'(idx_b) : ADDR_W'(idx_a));

    spi_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_SAMPLES)
    ) u_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (head_op.wdata),
        .rdata (ram_rdata)
    );

    // data stage: weight both neighbors
    assign a_val  = d_ok_a_reg ? a_data_reg : '0;
    assign b_val  = d_ok_b_reg ? $signed(ram_rdata) : '0;
    assign w_a    = (FRAC_BITS + 1)'(1 << FRAC_BITS) - {1'b0, d_op_reg.frac};
    assign prod_a = $signed({1'b0, w_a}) * a_val;
    assign prod_b = $signed({2'b00, d_op_reg.frac}) * b_val;

    // sum stage, floor by the fraction width
    assign m_sum = PSUM_W'(m_prod_a_reg) + PSUM_W'(m_prod_b_reg);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= 1'b0;
            d_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            phase_reg     <= is_interp && !phase_reg;
            d_valid_reg   <= pop;
            m_valid_reg   <= d_valid_reg;
            out_valid_reg <= m_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (pop)
            begin
                d_op_reg   <= head_op;
                d_ok_a_reg <= ok_a;
                d_ok_b_reg <= ok_b;
                a_data_reg <= $signed(ram_rdata);
            end
            m_op_reg     <= d_op_reg;
            m_prod_a_reg <= prod_a;
            m_prod_b_reg <= prod_b;
            sample_out_reg <= (m_op_reg.kind == OP_INTERP) ?
                              m_sum[FRAC_BITS+SAMPLE_W-1:FRAC_BITS] : '0;
            is_playing_reg     <= m_op_reg.playing;
            is_paused_reg      <= m_op_reg.paused;
            position_index_reg <= m_op_reg.pos_idx;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sample_out     = sample_out_reg;
    assign is_playing     = is_playing_reg;
    assign is_paused      = is_paused_reg;
    assign position_index = position_index_reg;

endmodule

`default_nettype wire

// ===== rtl/sample_playback_interpolator.sv =====
// Sampler voice with a linear-interpolating play position over a sample memory.
// Top level: configuration registers, front end, request queue and back end.
// Depends on spi_pkg, spi_front, spi_queue, spi_back.
//
// Every request (sample write, play, stop, pause, resume, tick, seek) returns
// exactly one result with the output sample and the voice state after it. The
// front end takes one request per cycle while the queue is not full and
// updates the play position at once; a two-entry queue feeds the back end,
// which owns the single-port sample memory. A tick that interpolates reads two
// neighboring samples one after the other on the memory port, while every other
// request makes one access there, so the back end takes the next request only
// after both reads. A result passes through the queue, the data stage, the sum stage and the output register.
// The sample memory is not cleared: a sample that was never written reads
// back as anything. The user must write configuration only while no request
// is in flight; the block does not enforce this.
`default_nettype none

module sample_playback_interpolator
    import spi_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        cfg_we,
    input  wire logic [CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]            cfg_wdata,
    // requests
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [2:0]                  cmd,
    input  wire logic [15:0]                 sample_index,
    input  wire logic signed [SAMPLE_W-1:0]  sample_value,
    input  wire logic [16:0]                 seek_fraction,
    // results
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]       sample_out,
    output logic                             is_playing,
    output logic                             is_paused,
    output logic [LEN_W-1:0]                 position_index
);

    logic signed [SPEED_W-1:0] speed_reg;
    logic [LEN_W-1:0]          sample_count_reg;
    logic                      loop_enable_reg;
    logic [LEN_W-1:0]          len;
    logic                      accept;
    op_t                       push_op;
    op_t                       head_op;
    logic                      head_valid;
    logic                      pop;
    logic                      q_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg        <= 24'sh010000;
            sample_count_reg <= '0;
            loop_enable_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SPEED: speed_reg        <= $signed(cfg_wdata[SPEED_W-1:0]);
                REG_COUNT: sample_count_reg <= cfg_wdata[LEN_W-1:0];
                REG_LOOP:  loop_enable_reg  <= cfg_wdata[0];
                default:   loop_enable_reg  <= loop_enable_reg;
            endcase
        end
    end

    // usable length
    assign len = (sample_count_reg > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : sample_count_reg;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    spi_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .sample_index  (sample_index),
        .sample_value  (sample_value),
        .seek_fraction (seek_fraction),
        .speed         (speed_reg),
        .loop_enable   (loop_enable_reg),
        .len           (len),
        .op            (push_op)
    );

    spi_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_op    (push_op),
        .pop        (pop),
        .head_op    (head_op),
        .head_valid (head_valid),
        .full       (q_full)
    );

    spi_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_op        (head_op),
        .head_valid     (head_valid),
        .pop            (pop),
        .len            (len),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .sample_out     (sample_out),
        .is_playing     (is_playing),
        .is_paused      (is_paused),
        .position_index (position_index)
    );

endmodule

`default_nettype wire

// ===== rtl/spi_checker.sv =====
// Port-level checks for the sampler voice, bound to the top level.
// Depends on spi_pkg.
`default_nettype none

module spi_checker
    import spi_pkg::*;
(
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_stall,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic signed [SAMPLE_W-1:0] sample_out,
    input wire logic                       is_playing,
    input wire logic                       is_paused,
    input wire logic [LEN_W-1:0]           position_index
);

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out)
            && $stable(position_index))
        else $error("held result changed");

    // only a playing voice makes sound
    a_silent_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_playing |-> sample_out == '0)
        else $error("sound while not playing");

    // a paused voice stays silent
    a_silent_paused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_paused |-> sample_out == '0)
        else $error("sound while paused");

    // position never passes the longest sample length
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> position_index <= LEN_W'(LEN_CAP))
        else $error("position beyond sample length");

    // leaving reset: nothing pending, ready for requests
    a_reset_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("not idle after reset");

endmodule

bind sample_playback_interpolator spi_checker u_spi_checker (.*);

`default_nettype wire
